// ===== rtl/video_mode_pixel_serializer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the video mode pixel serializer
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef VIDEO_MODE_PIXEL_SERIALIZER_ASSERT_SVH
`define VIDEO_MODE_PIXEL_SERIALIZER_ASSERT_SVH

// same-cycle implication
`define VMPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vmps assertion failed: same-cycle implication");

// next-cycle implication
`define VMPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vmps assertion failed: next-cycle implication");

`endif

// ===== rtl/vmps_pkg.sv =====
// ----------------------------------------------------------------------------
// vmps_pkg
// Types and constants shared by the serializer front, queue and back.
// ----------------------------------------------------------------------------
package vmps_pkg;

    localparam int ADDR_W        = 12;
    localparam int ROM_DEPTH_DEF = 4096;
    localparam int ROM_DATA_W    = 8;
    localparam int SAMPLE_W      = 14;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);

    // mode register indexes
    localparam logic CFG_ENHANCED  = 1'b0;
    localparam logic CFG_ALTERNATE = 1'b1;

    // glyph order detection: either marker entry holding this value
    // means the ROM stores glyphs mirrored
    localparam logic [ADDR_W-1:0]     MARK_ADDR_LO = 12'h121;
    localparam logic [ADDR_W-1:0]     MARK_ADDR_HI = 12'h122;
    localparam logic [ROM_DATA_W-1:0] MARK_VALUE   = 8'h3c;

    typedef enum logic [2:0] {
        OP_TEXT    = 3'd0,
        OP_DTEXT   = 3'd1,
        OP_LORES   = 3'd2,
        OP_DLORES  = 3'd3,
        OP_HIRES   = 3'd4,
        OP_DHIRES  = 3'd5,
        OP_ROM_WR  = 3'd6,
        OP_IGNORE  = 3'd7
    } op_t;

    // classified request as held in the queue
    typedef struct packed {
        op_t                    kind;
        logic [ADDR_W-1:0]      addr_a;   // text glyph, aux glyph or write addr
        logic [ADDR_W-1:0]      addr_b;   // main glyph (double text)
        logic [7:0]             main_byte;
        logic [7:0]             aux_byte;
        logic [2:0]             scan_line;
        logic                   column_odd;
        logic [ROM_DATA_W-1:0]  rom_data;
        logic                   span_end;
    } entry_t;

    // queue to back handshake
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_out_t;

endpackage

// ===== rtl/video_mode_pixel_serializer.sv =====
// An accepted request passes the queue, the ROM read stage and the output register before m_tvalid.
// Throughput: one request per cycle while the result side is not stalled; ROM reads for both
// double-text glyphs are made in the same cycle on the character ROM's two read ports.
// ROM writes take a queue slot, ignored operations none; neither produces a result.
// Reset (aresetn, synchronous, active low) clears queue, pipeline, carry and
// glyph markers; character ROM contents stay undefined until written.
// ----------------------------------------------------------------------------
// video_mode_pixel_serializer
// Turns display bytes into 14 video samples per byte in six display modes,
// with a writable character ROM for the text modes.
// ----------------------------------------------------------------------------
module video_mode_pixel_serializer #(
    parameter int ROM_DEPTH = vmps_pkg::ROM_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // main_byte[7:0], aux_byte[15:8], scan_line[18:16], column_odd[19],
    // rom_address[31:20], rom_data[39:32]
    input  logic [39:0] s_tdata,
    // operation[2:0]
    input  logic [2:0]  s_tuser,
    // end_of_span
    input  logic        s_tlast,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // samples[13:0], zero pad [15:14]
    output logic [15:0] m_tdata,
    // span_end
    output logic        m_tlast,
    // configuration writes: 0 enhanced_model, 1 alternate_charset
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic        cfg_wdata
);

    logic                          enhanced_model_reg, enhanced_model_next;
    logic                          alternate_charset_reg, alternate_charset_next;
    logic                          push;
    vmps_pkg::entry_t              push_entry;
    logic                          pop;
    vmps_pkg::q_out_t              q_out;
    logic [vmps_pkg::SAMPLE_W-1:0] samples;

    // config registers; the user must write them only while idle; the block does not enforce this
    always_comb begin
        enhanced_model_next    = enhanced_model_reg;
        alternate_charset_next = alternate_charset_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                vmps_pkg::CFG_ENHANCED:  enhanced_model_next    = cfg_wdata;
                vmps_pkg::CFG_ALTERNATE: alternate_charset_next = cfg_wdata;
                default:                 enhanced_model_next    = enhanced_model_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enhanced_model_reg    <= 1'b0;
            alternate_charset_reg <= 1'b0;
        end else begin
            enhanced_model_reg    <= enhanced_model_next;
            alternate_charset_reg <= alternate_charset_next;
        end
    end

    // front: decode request, form wrapped ROM addresses
    vmps_front #(
        .ROM_DEPTH (ROM_DEPTH)
    ) u_front (
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tuser           (s_tuser),
        .s_tdata           (s_tdata),
        .s_tlast           (s_tlast),
        .enhanced_model    (enhanced_model_reg),
        .alternate_charset (alternate_charset_reg),
        .push              (push),
        .push_entry        (push_entry)
    );

    // two-entry queue decouples request acceptance from result stalls
    vmps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .not_full   (s_tready),
        .q_out      (q_out)
    );

    // back: ROM access stage, sample forming and output register
    vmps_back #(
        .ROM_DEPTH (ROM_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_out    (q_out),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .samples  (samples),
        .span_end (m_tlast)
    );

    assign m_tdata = {2'b00, samples};

endmodule

// ===== rtl/vmps_ram.sv =====
// ----------------------------------------------------------------------------
// vmps_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module vmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/vmps_front.sv =====
// ----------------------------------------------------------------------------
// vmps_front
// Accepts requests, drops ignored ones, forms ROM addresses for the queue.
// ----------------------------------------------------------------------------
module vmps_front #(
    parameter int ROM_DEPTH = vmps_pkg::ROM_DEPTH_DEF
) (
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [2:0]            s_tuser,
    input  logic [39:0]           s_tdata,
    input  logic                  s_tlast,
    input  logic                  enhanced_model,
    input  logic                  alternate_charset,
    output logic                  push,
    output vmps_pkg::entry_t      push_entry
);

    localparam logic [vmps_pkg::ADDR_W:0] DEPTH_W = (vmps_pkg::ADDR_W + 1)'(ROM_DEPTH);

    // one conditional subtract: wraps correctly only for addresses below twice the depth
    function automatic logic [vmps_pkg::ADDR_W-1:0] wrap_addr(
        input logic [vmps_pkg::ADDR_W-1:0] a
    );
        logic [vmps_pkg::ADDR_W:0] w;
        w = {1'b0, a};
        if (w >= DEPTH_W) begin
            w = w - DEPTH_W;
        end
        return w[vmps_pkg::ADDR_W-1:0];
    endfunction

    vmps_pkg::op_t op;
    logic [7:0]    main_byte;
    logic [7:0]    aux_byte;
    logic [2:0]    scan_line;
    logic [8:0]    char_code;
    logic [vmps_pkg::ADDR_W-1:0] text_addr;
    logic [vmps_pkg::ADDR_W-1:0] aux_addr;
    logic [vmps_pkg::ADDR_W-1:0] main_addr;

    assign op        = vmps_pkg::op_t'(s_tuser);
    assign main_byte = s_tdata[7:0];
    assign aux_byte  = s_tdata[15:8];
    assign scan_line = s_tdata[18:16];

    // enhanced: full code with alternate set; otherwise low 6 bits only
    assign char_code = enhanced_model ? {alternate_charset, main_byte}
                                      : {3'b000, main_byte[5:0]};
    assign text_addr = {char_code, scan_line};
    assign aux_addr  = {alternate_charset, aux_byte, scan_line};
    assign main_addr = {alternate_charset, main_byte, scan_line};

    always_comb begin
        push_entry            = '0;
        push_entry.kind       = op;
        push_entry.main_byte  = main_byte;
        push_entry.aux_byte   = aux_byte;
        push_entry.scan_line  = scan_line;
        push_entry.column_odd = s_tdata[19];
        push_entry.rom_data   = s_tdata[39:32];
        push_entry.span_end   = s_tlast;
        push_entry.addr_b     = wrap_addr(main_addr);
        unique case (op)
            vmps_pkg::OP_TEXT:   push_entry.addr_a = wrap_addr(text_addr);
            vmps_pkg::OP_DTEXT:  push_entry.addr_a = wrap_addr(aux_addr);
            vmps_pkg::OP_ROM_WR: push_entry.addr_a = wrap_addr(s_tdata[31:20]);
            default:             push_entry.addr_a = '0;
        endcase
    end

    assign push = s_tvalid && s_tready && (op != vmps_pkg::OP_IGNORE);

endmodule

// ===== rtl/vmps_queue.sv =====
// ----------------------------------------------------------------------------
// vmps_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module vmps_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  vmps_pkg::entry_t      push_entry,
    input  logic                  pop,
    output logic                  not_full,
    output vmps_pkg::q_out_t      q_out
);

    vmps_pkg::entry_t                entries_reg [vmps_pkg::QUEUE_DEPTH];
    logic [vmps_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [vmps_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [vmps_pkg::CNT_W-1:0]      count_reg, count_next;

    localparam logic [vmps_pkg::CNT_W-1:0] FULL_CNT =
        vmps_pkg::CNT_W'(vmps_pkg::QUEUE_DEPTH);
    localparam logic [vmps_pkg::PTR_W-1:0] LAST_PTR =
        vmps_pkg::PTR_W'(vmps_pkg::QUEUE_DEPTH - 1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign not_full    = (count_reg != FULL_CNT);
    assign q_out.valid = (count_reg != '0);
    assign q_out.entry = entries_reg[rd_ptr_reg];

endmodule

// ===== rtl/vmps_back.sv =====
// ----------------------------------------------------------------------------
// vmps_back
// Executes queued requests: ROM access, sample forming, output register.
// ----------------------------------------------------------------------------
module vmps_back #(
    parameter int ROM_DEPTH = vmps_pkg::ROM_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  vmps_pkg::q_out_t               q_out,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vmps_pkg::SAMPLE_W-1:0]  samples,
    output logic                           span_end
);

`include "video_mode_pixel_serializer_assert.svh"

    localparam int AW = $clog2(ROM_DEPTH);

    function automatic logic [6:0] reverse7(input logic [6:0] v);
        logic [6:0] r;
        for (int j = 0; j < 7; j++) begin
            r[6-j] = v[j];
        end
        return r;
    endfunction

    vmps_pkg::entry_t                 head;
    logic                             is_write;
    logic                             r_valid_reg, r_valid_next;
    vmps_pkg::entry_t                 r_entry_reg;
    logic                             r_ready;
    logic                             r_adv;
    logic                             o_ready;
    logic                             o_valid_reg, o_valid_next;
    logic [vmps_pkg::SAMPLE_W-1:0]    o_samples_reg;
    logic                             o_span_end_reg;
    logic                             carry_reg, carry_next;
    logic [1:0]                       marks_reg, marks_next;
    logic [vmps_pkg::ROM_DATA_W-1:0]  rdata_a, rdata_b;
    logic [6:0]                       glyph_a, glyph_b;
    logic [6:0]                       pat;
    logic [3:0]                       nib_m, nib_a;
    logic [1:0]                       ph;
    logic [1:0]                       idx;
    logic [vmps_pkg::SAMPLE_W-1:0]    s;
    logic                             carry_out;

    assign head     = q_out.entry;
    assign is_write = (head.kind == vmps_pkg::OP_ROM_WR);
    assign o_ready  = !o_valid_reg || m_tready;
    assign r_adv    = r_valid_reg && o_ready;
    assign r_ready  = !r_valid_reg || o_ready;
    assign pop      = q_out.valid && r_ready;

    vmps_ram #(
        .WIDTH (vmps_pkg::ROM_DATA_W),
        .DEPTH (ROM_DEPTH)
    ) u_char_rom (
        .aclk    (aclk),
        .we      (pop && is_write),
        .waddr   (head.addr_a[AW-1:0]),
        .wdata   (head.rom_data),
        .re      (pop && !is_write),
        .raddr_a (head.addr_a[AW-1:0]),
        .raddr_b (head.addr_b[AW-1:0]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // marker tracking on ROM writes
    always_comb begin
        marks_next = marks_reg;
        if (pop && is_write) begin
            if (head.addr_a == vmps_pkg::MARK_ADDR_LO) begin
                marks_next[0] = (head.rom_data == vmps_pkg::MARK_VALUE);
            end else if (head.addr_a == vmps_pkg::MARK_ADDR_HI) begin
                marks_next[1] = (head.rom_data == vmps_pkg::MARK_VALUE);
            end
        end
    end

    // glyphs as seen by the display, mirrored when a marker is set
    assign glyph_a = (marks_reg != 2'b00) ? reverse7(rdata_a[6:0]) : rdata_a[6:0];
    assign glyph_b = (marks_reg != 2'b00) ? reverse7(rdata_b[6:0]) : rdata_b[6:0];

    always_comb begin
        s         = '0;
        carry_out = carry_reg;
        pat       = ~glyph_a;
        ph        = r_entry_reg.column_odd ? 2'd2 : 2'd0;
        nib_m     = r_entry_reg.scan_line[2] ? r_entry_reg.main_byte[7:4]
                                             : r_entry_reg.main_byte[3:0];
        nib_a     = r_entry_reg.scan_line[2] ? r_entry_reg.aux_byte[7:4]
                                             : r_entry_reg.aux_byte[3:0];
        idx       = '0;
        unique case (r_entry_reg.kind)
            vmps_pkg::OP_TEXT: begin
                for (int k = 0; k < 7; k++) begin
                    s[2*k]   = pat[6-k];
                    s[2*k+1] = pat[6-k];
                end
                carry_out = pat[0];
            end
            vmps_pkg::OP_DTEXT: begin
                for (int k = 0; k < 7; k++) begin
                    s[k]   = glyph_a[6-k];
                    s[7+k] = glyph_b[6-k];
                end
                carry_out = glyph_b[0];
            end
            vmps_pkg::OP_LORES: begin
                for (int i = 0; i < vmps_pkg::SAMPLE_W; i++) begin
                    idx  = 2'(i) + ph;
                    s[i] = nib_m[idx];
                end
                carry_out = r_entry_reg.column_odd ? nib_m[3] : nib_m[1];
            end
            vmps_pkg::OP_DLORES: begin
                for (int i = 0; i < 7; i++) begin
                    idx  = 2'(i) + 2'd3 + ph;
                    s[i] = nib_a[idx];
                end
                for (int i = 7; i < vmps_pkg::SAMPLE_W; i++) begin
                    idx  = 2'(i) + ph;
                    s[i] = nib_m[idx];
                end
                carry_out = r_entry_reg.column_odd ? nib_m[3] : nib_m[1];
            end
            vmps_pkg::OP_HIRES: begin
                if (r_entry_reg.main_byte[7]) begin
                    // half-pixel delay: previous level fills the first sample
                    s[0] = carry_reg;
                    for (int k = 0; k < 6; k++) begin
                        s[1+2*k] = r_entry_reg.main_byte[k];
                        s[2+2*k] = r_entry_reg.main_byte[k];
                    end
                    s[13] = r_entry_reg.main_byte[6];
                end else begin
                    for (int k = 0; k < 7; k++) begin
                        s[2*k]   = r_entry_reg.main_byte[k];
                        s[2*k+1] = r_entry_reg.main_byte[k];
                    end
                end
                carry_out = r_entry_reg.main_byte[6];
            end
            vmps_pkg::OP_DHIRES: begin
                s         = {r_entry_reg.main_byte[6:0], r_entry_reg.aux_byte[6:0]};
                carry_out = r_entry_reg.aux_byte[6];
            end
            default: begin
                s         = '0;
                carry_out = carry_reg;
            end
        endcase
    end

    always_comb begin
        if (pop) begin
            r_valid_next = !is_write;
        end else if (r_adv) begin
            r_valid_next = 1'b0;
        end else begin
            r_valid_next = r_valid_reg;
        end
        if (r_adv) begin
            o_valid_next = 1'b1;
        end else if (m_tready) begin
            o_valid_next = 1'b0;
        end else begin
            o_valid_next = o_valid_reg;
        end
        carry_next = r_adv ? carry_out : carry_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            carry_reg   <= 1'b0;
            marks_reg   <= 2'b00;
        end else begin
            r_valid_reg <= r_valid_next;
            o_valid_reg <= o_valid_next;
            carry_reg   <= carry_next;
            marks_reg   <= marks_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            r_entry_reg <= head;
        end
        if (r_adv) begin
            o_samples_reg  <= s;
            o_span_end_reg <= r_entry_reg.span_end;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign samples  = o_samples_reg;
    assign span_end = o_span_end_reg;

    // ROM writes complete at dequeue and never occupy the read stage
    `VMPS_ASSERT_IMP(a_no_write_in_read, aclk, aresetn, r_valid_reg, r_entry_reg.kind != vmps_pkg::OP_ROM_WR)
    // a blocked read stage keeps its request
    `VMPS_ASSERT_NEXT(a_read_holds, aclk, aresetn, r_valid_reg && !o_ready, r_valid_reg && $stable(r_entry_reg))
    // dequeue only from a non-empty queue
    `VMPS_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, pop, q_out.valid)
    // markers only move on a dequeued ROM write
    `VMPS_ASSERT_NEXT(a_marks_on_write, aclk, aresetn, !(pop && is_write), $stable(marks_reg))

endmodule

// ===== verif/video_mode_pixel_serializer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_mode_pixel_serializer_tb
// Self-checking bench for the pixel serializer. A directed table runs first,
// then random phases under several mode settings. Each accepted request goes
// through an in-bench model of the serializer, and every result is compared
// in order against that model. Both stream sides stall at random, and the
// result side is held off for a long stretch once so the input backs up.
// ----------------------------------------------------------------------------
module video_mode_pixel_serializer_tb;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 3;
    localparam int ROM_SIZE      = vmps_pkg::ROM_DEPTH_DEF;
    // pipeline is 2 deep plus a 2-entry queue; wait this long before a
    // mode write so trailing ROM writes have left the block
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 10;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 305;
    localparam int SQUEEZE_PHASE = 3;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        vmps_pkg::op_t op;
        logic [7:0]    main_byte;
        logic [7:0]    aux_byte;
        logic [2:0]    scan_line;
        logic          column_odd;
        logic [11:0]   rom_addr;
        logic [7:0]    rom_data;
        logic          span_last;
    } request_t;

    typedef struct packed {
        logic        fixed;          // use fixed_samples instead of the model
        logic [13:0] fixed_samples;
        request_t    req;
    } table_row_t;

    typedef struct packed {
        logic [13:0] samples;
        logic        span_end;
    } video_word_t;

    // DUT ports
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // main_byte[7:0], aux_byte[15:8], scan_line[18:16], column_odd[19],
    // rom_address[31:20], rom_data[39:32]
    logic [39:0] s_tdata   = '0;
    // operation[2:0]
    logic [2:0]  s_tuser   = vmps_pkg::OP_IGNORE;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // samples[13:0], zero pad [15:14]
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = vmps_pkg::CFG_ENHANCED;
    logic        cfg_wdata = 1'b0;

    // serializer model state
    logic [7:0]  glyph_rom [0:ROM_SIZE-1];
    bit          rom_loaded [0:ROM_SIZE-1];   // entries safe to read
    logic        level_carry   = 1'b0;
    logic [1:0]  mark_bits     = 2'b00;
    logic        cfg_enhanced  = 1'b0;
    logic        cfg_alternate = 1'b0;

    video_word_t pending_samples [$];
    table_row_t  stim_table [$];

    int unsigned items_sent   = 0;
    int unsigned fault_count  = 0;
    int unsigned cycle_count  = 0;
    bit          send_idle    = 1'b1;
    logic        recv_idle    = 1'b1;
    logic        hold_off     = 1'b0;
    logic        hold_off_arm = 1'b0;

    video_mode_pixel_serializer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Serializer model
    // ------------------------------------------------------------------

    // Glyph row read; a marker entry holding the magic value means the ROM
    // stores glyphs mirrored, so the low 7 bits come back reversed.
    function automatic logic [6:0] fetch_glyph(input logic [11:0] addr);
        logic [7:0] g;
        logic [6:0] flipped;
        g = glyph_rom[addr % ROM_SIZE];
        for (int j = 0; j < 7; j++)
            flipped[6 - j] = g[j];
        return (mark_bits == 2'b00) ? g[6:0] : flipped;
    endfunction

    // Applies one request to the model; returns 1 when it yields a result.
    function automatic bit render_samples(input request_t r, output logic [13:0] s);
        logic [8:0]  ch;
        logic [6:0]  pat;
        logic [6:0]  pat_main;
        logic [3:0]  nib;
        logic [3:0]  nib_aux;
        logic [11:0] bank;
        int          ph;
        s    = '0;
        ph   = r.column_odd ? 2 : 0;
        bank = cfg_alternate ? 12'h800 : 12'h000;
        nib  = r.scan_line[2] ? r.main_byte[7:4] : r.main_byte[3:0];
        nib_aux = r.scan_line[2] ? r.aux_byte[7:4] : r.aux_byte[3:0];
        case (r.op)
            vmps_pkg::OP_ROM_WR: begin
                glyph_rom[r.rom_addr % ROM_SIZE] = r.rom_data;
                if (r.rom_addr == vmps_pkg::MARK_ADDR_LO)
                    mark_bits[0] = (r.rom_data == vmps_pkg::MARK_VALUE);
                else if (r.rom_addr == vmps_pkg::MARK_ADDR_HI)
                    mark_bits[1] = (r.rom_data == vmps_pkg::MARK_VALUE);
                return 1'b0;
            end
            vmps_pkg::OP_TEXT: begin
                // normal text always comes out inverted
                ch  = ({1'b0, r.main_byte} | (cfg_alternate ? 9'h100 : 9'h000))
                      & (cfg_enhanced ? 9'h1ff : 9'h03f);
                pat = ~fetch_glyph({ch, r.scan_line});
                for (int k = 0; k < 7; k++) begin
                    s[2 * k]     = pat[6 - k];
                    s[2 * k + 1] = pat[6 - k];
                end
                level_carry = pat[0];
            end
            vmps_pkg::OP_DTEXT: begin
                pat      = fetch_glyph(bank + {1'b0, r.aux_byte, r.scan_line});
                pat_main = fetch_glyph(bank + {1'b0, r.main_byte, r.scan_line});
                for (int k = 0; k < 7; k++) begin
                    s[k]     = pat[6 - k];
                    s[7 + k] = pat_main[6 - k];
                end
                level_carry = pat_main[0];
            end
            vmps_pkg::OP_LORES: begin
                for (int i = 0; i < 14; i++)
                    s[i] = nib[(i + ph) % 4];
                level_carry = nib[r.column_odd ? 3 : 1];
            end
            vmps_pkg::OP_DLORES: begin
                for (int i = 0; i < 7; i++)
                    s[i] = nib_aux[(i + 3 + ph) % 4];
                for (int i = 7; i < 14; i++)
                    s[i] = nib[(i + ph) % 4];
                level_carry = nib[r.column_odd ? 3 : 1];
            end
            vmps_pkg::OP_HIRES: begin
                if (r.main_byte[7]) begin
                    // half-pixel delay: previous level fills the first sample
                    s[0] = level_carry;
                    for (int k = 0; k < 6; k++) begin
                        s[1 + 2 * k] = r.main_byte[k];
                        s[2 + 2 * k] = r.main_byte[k];
                    end
                    s[13] = r.main_byte[6];
                end else begin
                    for (int k = 0; k < 7; k++) begin
                        s[2 * k]     = r.main_byte[k];
                        s[2 * k + 1] = r.main_byte[k];
                    end
                end
                level_carry = r.main_byte[6];
            end
            vmps_pkg::OP_DHIRES: begin
                s = {r.main_byte[6:0], r.aux_byte[6:0]};
                level_carry = r.aux_byte[6];
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic request_t random_fields();
        request_t r;
        r.op         = vmps_pkg::OP_IGNORE;
        r.main_byte  = 8'($urandom_range(0, 255));
        r.aux_byte   = 8'($urandom_range(0, 255));
        r.scan_line  = 3'($urandom_range(0, 7));
        r.column_odd = 1'($urandom_range(0, 1));
        r.rom_addr   = 12'($urandom_range(0, ROM_SIZE - 1));
        r.rom_data   = 8'($urandom_range(0, 255));
        r.span_last  = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    // Offer one request, wait for the handshake, then book the expected
    // result. Valid stays up across back-to-back requests.
    task automatic send_request(input request_t r, input bit fixed,
                                input logic [13:0] fixed_s);
        int          gap;
        logic [13:0] s;
        video_word_t w;
        gap = send_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {r.rom_data, r.rom_addr, r.column_odd, r.scan_line,
                     r.aux_byte, r.main_byte};
        s_tuser  <= r.op;
        s_tlast  <= r.span_last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (render_samples(r, s)) begin
            w.samples  = fixed ? fixed_s : s;
            w.span_end = r.span_last;
            pending_samples.push_back(w);
        end
        if (r.op == vmps_pkg::OP_ROM_WR)
            rom_loaded[r.rom_addr % ROM_SIZE] = 1'b1;
        if (r.op != vmps_pkg::OP_IGNORE)
            items_sent++;
    endtask

    // Load a glyph entry first if nothing has been written there yet.
    task automatic ensure_glyph(input logic [11:0] addr);
        request_t w;
        if (!rom_loaded[addr % ROM_SIZE]) begin
            w          = random_fields();
            w.op       = vmps_pkg::OP_ROM_WR;
            w.rom_addr = addr;
            send_request(w, 1'b0, 14'd0);
        end
    endtask

    // Mode writes only with the block drained.
    task automatic program_mode(input logic enh, input logic alt);
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= vmps_pkg::CFG_ENHANCED;
        cfg_wdata <= enh;
        @(posedge aclk);
        cfg_index <= vmps_pkg::CFG_ALTERNATE;
        cfg_wdata <= alt;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        cfg_enhanced  = enh;
        cfg_alternate = alt;
    endtask

    task automatic add_row(input vmps_pkg::op_t op, input logic [7:0] mb,
                           input logic [7:0] ab,
                           input logic [2:0] line, input logic odd,
                           input logic [11:0] wa, input logic [7:0] wd,
                           input logic last, input logic fixed,
                           input logic [13:0] fs);
        table_row_t t;
        t.fixed          = fixed;
        t.fixed_samples  = fs;
        t.req.op         = op;
        t.req.main_byte  = mb;
        t.req.aux_byte   = ab;
        t.req.scan_line  = line;
        t.req.column_odd = odd;
        t.req.rom_addr   = wa;
        t.req.rom_data   = wd;
        t.req.span_last  = last;
        stim_table.push_back(t);
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus the long hold-off when armed
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                while (hold_off) @(posedge aclk);
            end
            stall = recv_idle ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && !hold_off);
        end
    end

    // long receiver hold-off, counted here so the sender keeps pushing
    initial begin : hold_off_timer
        wait (hold_off_arm);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // in-order compare of every accepted result against the oldest entry
    always @(posedge aclk) begin : result_check
        video_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                note_fault($sformatf("unexpected result samples=%04h last=%0b",
                                     m_tdata, m_tlast));
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata !== {2'b00, want.samples} || m_tlast !== want.span_end)
                    note_fault($sformatf("samples exp %04h got %04h, last exp %0b got %0b",
                                         {2'b00, want.samples}, m_tdata,
                                         want.span_end, m_tlast));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        request_t    r;
        logic [8:0]  ch;
        logic [11:0] bank;
        int unsigned phase_start;
        int          pick;
        logic        enh;
        logic        alt;

        // Directed part, run with both mode bits clear. Glyph entries are
        // loaded before any text request reads them.
        add_row(vmps_pkg::OP_ROM_WR, 8'h00, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b0, 14'h0000);
        add_row(vmps_pkg::OP_TEXT,   8'h00, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h3fff);
        add_row(vmps_pkg::OP_ROM_WR, 8'h00, 8'h00, 3'd0, 1'b0, 12'h1ff, 8'hff,
                1'b0, 1'b0, 14'h0000);
        // only the low 6 code bits count, so 0xff hits glyph 0x3f
        add_row(vmps_pkg::OP_TEXT,   8'hff, 8'h00, 3'd7, 1'b0, 12'h000, 8'h00,
                1'b1, 1'b1, 14'h0000);
        add_row(vmps_pkg::OP_DTEXT,  8'h00, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h0000);
        add_row(vmps_pkg::OP_DTEXT,  8'h3f, 8'h3f, 3'd7, 1'b0, 12'h000, 8'h00,
                1'b1, 1'b1, 14'h3fff);
        add_row(vmps_pkg::OP_LORES,  8'h00, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h0000);
        add_row(vmps_pkg::OP_LORES,  8'hff, 8'h00, 3'd4, 1'b1, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h3fff);
        add_row(vmps_pkg::OP_LORES,  8'ha5, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b0, 14'h0000);
        add_row(vmps_pkg::OP_DLORES, 8'hff, 8'hff, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h3fff);
        add_row(vmps_pkg::OP_DLORES, 8'hc3, 8'h3c, 3'd4, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b0, 14'h0000);
        add_row(vmps_pkg::OP_DLORES, 8'h5a, 8'ha5, 3'd0, 1'b1, 12'h000, 8'h00,
                1'b1, 1'b0, 14'h0000);
        // hires: carry chain 1 -> 0 -> 1 exercises the half-pixel fill
        add_row(vmps_pkg::OP_HIRES,  8'h00, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h0000);
        add_row(vmps_pkg::OP_HIRES,  8'h7f, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h3fff);
        add_row(vmps_pkg::OP_HIRES,  8'h80, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h0001);
        add_row(vmps_pkg::OP_HIRES,  8'hff, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h3ffe);
        add_row(vmps_pkg::OP_HIRES,  8'hc0, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b1, 1'b1, 14'h2001);
        add_row(vmps_pkg::OP_DHIRES, 8'h00, 8'h7f, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h007f);
        add_row(vmps_pkg::OP_DHIRES, 8'hff, 8'h80, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b1, 14'h3f80);
        // ignored operation with every field bit set: no result
        add_row(vmps_pkg::OP_IGNORE, 8'hff, 8'hff, 3'd7, 1'b1, 12'hfff, 8'hff,
                1'b1, 1'b0, 14'h0000);
        add_row(vmps_pkg::OP_ROM_WR, 8'h00, 8'h00, 3'd0, 1'b0, 12'h008, 8'h01,
                1'b0, 1'b0, 14'h0000);
        // mirrored glyph marker on, read, marker off, read again
        add_row(vmps_pkg::OP_ROM_WR, 8'h00, 8'h00, 3'd0, 1'b0,
                vmps_pkg::MARK_ADDR_LO, vmps_pkg::MARK_VALUE,
                1'b0, 1'b0, 14'h0000);
        add_row(vmps_pkg::OP_TEXT,   8'h01, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b0, 1'b0, 14'h0000);
        add_row(vmps_pkg::OP_ROM_WR, 8'h00, 8'h00, 3'd0, 1'b0,
                vmps_pkg::MARK_ADDR_LO, 8'h00,
                1'b0, 1'b0, 14'h0000);
        add_row(vmps_pkg::OP_TEXT,   8'h41, 8'h00, 3'd0, 1'b0, 12'h000, 8'h00,
                1'b1, 1'b0, 14'h0000);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        program_mode(1'b0, 1'b0);
        foreach (stim_table[i])
            send_request(stim_table[i].req, stim_table[i].fixed, stim_table[i].fixed_samples);
        s_tvalid <= 1'b0;

        // Random phases: every mode combination, then two random ones.
        // Phase 1 runs with no idling at all; the squeeze phase keeps the
        // sender busy while the receiver is held off.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin enh = 1'b1; alt = 1'b0; end
                1: begin enh = 1'b1; alt = 1'b1; end
                2: begin enh = 1'b0; alt = 1'b1; end
                3: begin enh = 1'b0; alt = 1'b0; end
                default: begin
                    enh = 1'($urandom_range(0, 1));
                    alt = 1'($urandom_range(0, 1));
                end
            endcase
            program_mode(enh, alt);
            send_idle = (p != 1 && p != SQUEEZE_PHASE);
            recv_idle <= (p != 1);
            phase_start = items_sent;

            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (p == SQUEEZE_PHASE && !hold_off_arm && items_sent - phase_start >= 100)
                    hold_off_arm <= 1'b1;
                pick = $urandom_range(0, 99);
                r    = random_fields();
                if (pick < 22) begin
                    r.op = vmps_pkg::OP_TEXT;
                    ch   = ({1'b0, r.main_byte} | (cfg_alternate ? 9'h100 : 9'h000))
                           & (cfg_enhanced ? 9'h1ff : 9'h03f);
                    ensure_glyph({ch, r.scan_line});
                end else if (pick < 40) begin
                    r.op = vmps_pkg::OP_DTEXT;
                    bank = cfg_alternate ? 12'h800 : 12'h000;
                    ensure_glyph(bank + {1'b0, r.aux_byte, r.scan_line});
                    ensure_glyph(bank + {1'b0, r.main_byte, r.scan_line});
                end else if (pick < 50) begin
                    r.op = vmps_pkg::OP_LORES;
                end else if (pick < 60) begin
                    r.op = vmps_pkg::OP_DLORES;
                end else if (pick < 72) begin
                    r.op = vmps_pkg::OP_HIRES;
                end else if (pick < 82) begin
                    r.op = vmps_pkg::OP_DHIRES;
                end else if (pick < 95) begin
                    r.op = vmps_pkg::OP_ROM_WR;
                    // a third of the writes go to the marker entries, half of
                    // those with the mirror value, so glyph order flips often
                    if ($urandom_range(0, 2) == 0) begin
                        r.rom_addr = $urandom_range(0, 1) ? vmps_pkg::MARK_ADDR_HI
                                                          : vmps_pkg::MARK_ADDR_LO;
                        if ($urandom_range(0, 1))
                            r.rom_data = vmps_pkg::MARK_VALUE;
                    end
                end else begin
                    r.op = vmps_pkg::OP_IGNORE;
                end
                send_request(r, 1'b0, 14'd0);
            end
            s_tvalid <= 1'b0;
        end

        // drain, then give stray results a chance to show up
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_count == 0 && pending_samples.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/vmps_pkg.sv
rtl/vmps_ram.sv
rtl/vmps_front.sv
rtl/vmps_queue.sv
rtl/vmps_back.sv
rtl/video_mode_pixel_serializer.sv
verif/video_mode_pixel_serializer_tb.sv
